>>> rtl/core/tsafp_pkg.sv
// Shared types and constants of the transport-stream adaptation field parser.
`timescale 1ns / 1ps
`default_nettype none

package tsafp_pkg;

   // Depth of the queue between the byte sequencer and the field assembler.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // PCR and OPCR are base * 300 + extension.
   localparam int CLOCK_REF_SCALE = 300;

   // Byte counts of the multi-byte groups.
   localparam int PCR_BYTES   = 6;
   localparam int LTW_BYTES   = 2;
   localparam int PIECE_BYTES = 3;
   localparam int SEAM_BYTES  = 5;

   localparam int NUM_PHASES  = 13;

   // Result channel packing.
   localparam int RSP_TDATA_W = 200;

   // Position of the sequencer inside one adaptation field.
   typedef enum logic [3:0] {
      PH_IDLE     = 4'd0,
      PH_FLAGS    = 4'd1,
      PH_PCR      = 4'd2,
      PH_OPCR     = 4'd3,
      PH_SPLICE   = 4'd4,
      PH_PRIVLEN  = 4'd5,
      PH_PRIVSKIP = 4'd6,
      PH_EXTLEN   = 4'd7,
      PH_EXTFLAGS = 4'd8,
      PH_LTW      = 4'd9,
      PH_PIECE    = 4'd10,
      PH_SEAM     = 4'd11,
      PH_STUFF    = 4'd12
   } phase_type;

   // What a queued entry asks the field assembler to do.
   typedef enum logic [3:0] {
      OP_NONE     = 4'd0,
      OP_START    = 4'd1,
      OP_FLAGS    = 4'd2,
      OP_PCR      = 4'd3,
      OP_OPCR     = 4'd4,
      OP_SPLICE   = 4'd5,
      OP_PRIVLEN  = 4'd6,
      OP_EXTFLAGS = 4'd7,
      OP_LTW      = 4'd8,
      OP_PIECE    = 4'd9,
      OP_SEAM     = 4'd10
   } op_kind_type;

   // One queue entry: an operation, the gathered bytes it refers to, and
   // whether it closes the field.
   typedef struct packed {
      op_kind_type kind;
      logic [47:0] value;
      logic        last;
      logic        trunc;
   } entry_type;

   // One parsed adaptation field.
   typedef struct packed {
      logic [7:0]        flags;
      logic [41:0]       pcr;
      logic [41:0]       opcr;
      logic signed [7:0] countdown_byte;
      logic [7:0]        private_length;
      logic [3:0]        ext_flags;
      logic [14:0]       window_offset;
      logic [21:0]       piece_rate;
      logic [3:0]        splice_code;
      logic [32:0]       next_dts;
      logic [7:0]        field_length;
      logic              truncated;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/tsafp_front.sv
// Byte sequencer: tracks the parse phase and turns bytes into queue entries.
`timescale 1ns / 1ps
`default_nettype none

module tsafp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire logic                 first_byte,
   input  wire logic [7:0]           data_byte,
   output logic                      push,
   output tsafp_pkg::entry_type      push_entry
);

   tsafp_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]  idx_ff, idx_in;
   logic [39:0] gather_ff, gather_in;
   logic [7:0]  skip_ff, skip_in;
   logic [7:0]  flags_ff, flags_in;
   logic [2:0]  ext_ff, ext_in;
   logic [2:0]  idx_inc;
   logic        advance;

   // First phase after 'from' whose item is present in this field.
   function automatic tsafp_pkg::phase_type next_phase(
      input tsafp_pkg::phase_type from,
      input logic [7:0]           flg,
      input logic [2:0]           ext,
      input logic                 skip_nz
   );
      logic [tsafp_pkg::NUM_PHASES-1:0] present;
      logic                             found;
      tsafp_pkg::phase_type             res;
      present = '0;
      present[tsafp_pkg::PH_PCR]      = flg[4];
      present[tsafp_pkg::PH_OPCR]     = flg[3];
      present[tsafp_pkg::PH_SPLICE]   = flg[2];
      present[tsafp_pkg::PH_PRIVLEN]  = flg[1];
      present[tsafp_pkg::PH_PRIVSKIP] = flg[1] & skip_nz;
      present[tsafp_pkg::PH_EXTLEN]   = flg[0];
      present[tsafp_pkg::PH_EXTFLAGS] = flg[0];
      present[tsafp_pkg::PH_LTW]      = ext[2];
      present[tsafp_pkg::PH_PIECE]    = ext[1];
      present[tsafp_pkg::PH_SEAM]     = ext[0];
      present[tsafp_pkg::PH_STUFF]    = 1'b1;
      found = 1'b0;
      res   = tsafp_pkg::PH_STUFF;
      for (int i = 0; i < tsafp_pkg::NUM_PHASES; i++) begin
         if (!found && (i > int'(from)) && present[i]) begin
            res   = tsafp_pkg::phase_type'(i[3:0]);
            found = 1'b1;
         end
      end
      return res;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= tsafp_pkg::PH_IDLE;
         bytes_left_ff <= '0;
         skip_ff       <= '0;
         idx_ff        <= '0;
      end else begin
         phase_ff      <= phase_in;
         bytes_left_ff <= bytes_left_in;
         skip_ff       <= skip_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      gather_ff <= gather_in;
      flags_ff  <= flags_in;
      ext_ff    <= ext_in;
   end

   always_comb begin
      phase_in      = phase_ff;
      bytes_left_in = bytes_left_ff;
      idx_in        = idx_ff;
      gather_in     = gather_ff;
      skip_in       = skip_ff;
      flags_in      = flags_ff;
      ext_in        = ext_ff;
      idx_inc       = idx_ff + 3'd1;
      advance       = 1'b0;

      push_entry.kind  = tsafp_pkg::OP_NONE;
      push_entry.value = {gather_ff, data_byte};
      push_entry.last  = 1'b0;
      push_entry.trunc = 1'b0;

      if (fire) begin
         if (first_byte) begin
            // A length byte always starts over, dropping any unfinished field.
            phase_in         = (data_byte == 8'd0) ? tsafp_pkg::PH_IDLE : tsafp_pkg::PH_FLAGS;
            bytes_left_in    = data_byte;
            idx_in           = '0;
            gather_in        = '0;
            skip_in          = '0;
            flags_in         = '0;
            ext_in           = '0;
            push_entry.kind  = tsafp_pkg::OP_START;
            push_entry.value = {40'd0, data_byte};
            push_entry.last  = (data_byte == 8'd0);
         end else if (phase_ff != tsafp_pkg::PH_IDLE) begin
            bytes_left_in = bytes_left_ff - 8'd1;
            case (phase_ff)
               tsafp_pkg::PH_FLAGS: begin
                  flags_in        = data_byte;
                  push_entry.kind = tsafp_pkg::OP_FLAGS;
                  advance         = 1'b1;
               end
               tsafp_pkg::PH_PCR, tsafp_pkg::PH_OPCR: begin
                  if (idx_inc >= 3'(tsafp_pkg::PCR_BYTES)) begin
                     push_entry.kind = (phase_ff == tsafp_pkg::PH_PCR) ?
                                       tsafp_pkg::OP_PCR : tsafp_pkg::OP_OPCR;
                     advance = 1'b1;
                  end else begin
                     idx_in    = idx_inc;
                     gather_in = {gather_ff[31:0], data_byte};
                  end
               end
               tsafp_pkg::PH_SPLICE: begin
                  push_entry.kind = tsafp_pkg::OP_SPLICE;
                  advance         = 1'b1;
               end
               tsafp_pkg::PH_PRIVLEN: begin
                  push_entry.kind = tsafp_pkg::OP_PRIVLEN;
                  skip_in         = data_byte;
                  advance         = 1'b1;
               end
               tsafp_pkg::PH_PRIVSKIP: begin
                  skip_in = skip_ff - 8'd1;
                  advance = (skip_in == 8'd0);
               end
               tsafp_pkg::PH_EXTLEN: begin
                  // The extension length is not used; the flags byte follows.
                  advance = 1'b1;
               end
               tsafp_pkg::PH_EXTFLAGS: begin
                  ext_in          = data_byte[7:5];
                  push_entry.kind = tsafp_pkg::OP_EXTFLAGS;
                  advance         = 1'b1;
               end
               tsafp_pkg::PH_LTW: begin
                  if (idx_inc >= 3'(tsafp_pkg::LTW_BYTES)) begin
                     push_entry.kind = tsafp_pkg::OP_LTW;
                     advance         = 1'b1;
                  end else begin
                     idx_in    = idx_inc;
                     gather_in = {gather_ff[31:0], data_byte};
                  end
               end
               tsafp_pkg::PH_PIECE: begin
                  if (idx_inc >= 3'(tsafp_pkg::PIECE_BYTES)) begin
                     push_entry.kind = tsafp_pkg::OP_PIECE;
                     advance         = 1'b1;
                  end else begin
                     idx_in    = idx_inc;
                     gather_in = {gather_ff[31:0], data_byte};
                  end
               end
               tsafp_pkg::PH_SEAM: begin
                  if (idx_inc >= 3'(tsafp_pkg::SEAM_BYTES)) begin
                     push_entry.kind = tsafp_pkg::OP_SEAM;
                     advance         = 1'b1;
                  end else begin
                     idx_in    = idx_inc;
                     gather_in = {gather_ff[31:0], data_byte};
                  end
               end
               default: begin
                  // Stuffing and unparsed extension bytes are only counted.
               end
            endcase

            if (advance) begin
               phase_in  = next_phase(phase_ff, flags_in, ext_in, skip_in != 8'd0);
               idx_in    = '0;
               gather_in = '0;
            end

            if (bytes_left_in == 8'd0) begin
               // Ending anywhere but in stuffing means a flagged value was cut short.
               push_entry.last  = 1'b1;
               push_entry.trunc = (phase_in != tsafp_pkg::PH_STUFF);
               phase_in         = tsafp_pkg::PH_IDLE;
               idx_in           = '0;
               gather_in        = '0;
               skip_in          = '0;
            end
         end
      end

      push = (push_entry.kind != tsafp_pkg::OP_NONE) || push_entry.last;
   end

   // The sequencer is idle exactly when no declared bytes remain.
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == tsafp_pkg::PH_IDLE) == (bytes_left_ff == 8'd0))
      else $error("phase and byte count disagree");

   // Private bytes are only pending while they are being skipped.
   assert property (@(posedge clock) disable iff (reset)
      (skip_ff != 8'd0) |-> (phase_ff == tsafp_pkg::PH_PRIVSKIP))
      else $error("skip count left over outside private data");

endmodule

`default_nettype wire

>>> rtl/core/tsafp_queue.sv
// Short entry queue between the byte sequencer and the field assembler.
`timescale 1ns / 1ps
`default_nettype none

module tsafp_queue #(
   parameter int DEPTH = tsafp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  tsafp_pkg::entry_type      push_entry,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      head_valid,
   output tsafp_pkg::entry_type      head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   tsafp_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue fill count beyond depth");

   assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("entry taken from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && full) |-> pop)
      else $error("entry written into a full queue");

endmodule

`default_nettype wire

>>> rtl/core/tsafp_back.sv
// Field assembler: applies queued entries to the held values and registers results.
`timescale 1ns / 1ps
`default_nettype none

module tsafp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 head_valid,
   input  tsafp_pkg::entry_type      head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output tsafp_pkg::result_type     result
);

   tsafp_pkg::result_type held_ff, held_in;
   tsafp_pkg::result_type result_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        out_free;
   logic [32:0] ref_base;
   logic [41:0] clock_ref;

   // PCR and OPCR: 33-bit base in the top bits, 9-bit extension at the bottom.
   assign ref_base  = head.value[47:15];
   assign clock_ref = 42'(ref_base) * 42'(tsafp_pkg::CLOCK_REF_SCALE)
                    + 42'(head.value[8:0]);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = head_valid && (!head.last || out_free);

   always_comb begin
      held_in = held_ff;
      case (head.kind)
         tsafp_pkg::OP_START: begin
            held_in              = '0;
            held_in.field_length = head.value[7:0];
         end
         tsafp_pkg::OP_FLAGS: begin
            held_in.flags = head.value[7:0];
         end
         tsafp_pkg::OP_PCR: begin
            held_in.pcr = clock_ref;
         end
         tsafp_pkg::OP_OPCR: begin
            held_in.opcr = clock_ref;
         end
         tsafp_pkg::OP_SPLICE: begin
            held_in.countdown_byte = head.value[7:0];
         end
         tsafp_pkg::OP_PRIVLEN: begin
            held_in.private_length = head.value[7:0];
         end
         tsafp_pkg::OP_EXTFLAGS: begin
            held_in.ext_flags[3:1] = held_ff.ext_flags[3:1] | head.value[7:5];
         end
         tsafp_pkg::OP_LTW: begin
            held_in.ext_flags[0]  = held_ff.ext_flags[0] | head.value[15];
            held_in.window_offset = head.value[14:0];
         end
         tsafp_pkg::OP_PIECE: begin
            held_in.piece_rate = head.value[21:0];
         end
         tsafp_pkg::OP_SEAM: begin
            held_in.splice_code = head.value[39:36];
            held_in.next_dts    = {head.value[35:33], head.value[31:17], head.value[15:1]};
         end
         default: begin
         end
      endcase
      held_in.truncated = head.trunc;

      rsp_valid_in = rsp_valid_ff;
      if (pop && head.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         held_ff <= held_in;
      end
      if (pop && head.last) begin
         result_ff <= held_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign result    = result_ff;

   // A new result only appears after a closing entry left the queue.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(pop && head.last))
      else $error("result raised without a closing entry");

endmodule

`default_nettype wire

>>> rtl/core/ts_adaptation_field_parser_core.sv
// Top level of the transport-stream adaptation field parser.
// Usage:
// The req channel carries one adaptation field byte per item. An item with
// req_tuser high is the field length byte and starts a new field; any field
// still open is dropped without a result. Bytes that arrive while no field
// is open are discarded. The rsp channel returns one item per field, after
// the field's last declared byte, or right after a length byte of zero.
// Path: the last byte's entry is registered in the queue, then the result in
// the output register; earlier entries or a stalled rsp side hold it back.
// Throughput: one byte per cycle while the queue has room; the assembler
// retires one queue entry per cycle unless a closing entry waits on a held
// result; the PCR and OPCR multiply by 300 sits in that single assembler step.
// Stalls: a result waits in the output register while rsp_tready is low.
// Bytes keep flowing into the entry queue until it fills, after which
// req_tready drops; at most one result is held at a time.
// Reset: synchronous and active high; it empties the queue, drops any open
// field and clears rsp_tvalid.
`timescale 1ns / 1ps
`default_nettype none

module ts_adaptation_field_parser_core #(
   parameter int QUEUE_DEPTH = tsafp_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,

   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // data_byte[7:0]
   input  wire logic [7:0]                        req_tdata,
   // first_byte
   input  wire logic                              req_tuser,

   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // flags[7:0], pcr[49:8], opcr[91:50], countdown_byte[99:92],
   // private_length[107:100], ext_flags[111:108], window_offset[126:112],
   // piece_rate[148:127], splice_code[152:149], next_dts[185:153],
   // field_length[193:186], zero fill[199:194]
   output logic [tsafp_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // truncated
   output logic                                   rsp_tuser
);

   logic                  req_fire;
   logic                  push;
   logic                  pop;
   logic                  queue_full;
   logic                  head_valid;
   tsafp_pkg::entry_type  push_entry;
   tsafp_pkg::entry_type  head;
   tsafp_pkg::result_type result;

   assign req_tready = !queue_full;
   assign req_fire   = req_tvalid && req_tready;

   tsafp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .first_byte (req_tuser),
      .data_byte  (req_tdata),
      .push       (push),
      .push_entry (push_entry)
   );

   tsafp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .head_valid (head_valid),
      .head       (head)
   );

   tsafp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .result     (result)
   );

   assign rsp_tdata = {6'd0,
                       result.field_length,
                       result.next_dts,
                       result.splice_code,
                       result.piece_rate,
                       result.window_offset,
                       result.ext_flags,
                       result.private_length,
                       result.countdown_byte,
                       result.opcr,
                       result.pcr,
                       result.flags};
   assign rsp_tuser = result.truncated;

endmodule

`default_nettype wire

>>> tb/ts_adaptation_field_parser_checker.sv
// Byte-level predictor and result comparison for the adaptation field parser.
`timescale 1ns / 1ps

module ts_adaptation_field_parser_checker (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   input  wire logic                         req_tready,
   input  wire logic [7:0]                   req_tdata,
   input  wire logic                         req_tuser,
   input  wire logic                         rsp_tvalid,
   input  wire logic                         rsp_tready,
   input  wire logic [tsafp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                         rsp_tuser,
   output int                                failures,
   output int                                outstanding,
   output int                                results_checked
);

   logic [7:0]            bytes_to_go;
   logic [7:0]            skip_to_go;
   tsafp_pkg::phase_type  phase;
   logic [2:0]            group_count;
   logic [47:0]           group_bytes;
   tsafp_pkg::result_type field_acc;
   tsafp_pkg::result_type expected_fields[$];

   task automatic clear_field();
      bytes_to_go = '0;
      skip_to_go  = '0;
      phase       = tsafp_pkg::PH_IDLE;
      group_count = '0;
      group_bytes = '0;
      field_acc   = '0;
   endtask

   // Flag bits: pcr 4, opcr 3, splice 2, private 1, extension 0;
   // extension flags: ltw 3, piecewise 2, seamless splice 1.
   function automatic logic phase_wanted(tsafp_pkg::phase_type p);
      case (p)
         tsafp_pkg::PH_PCR:      return field_acc.flags[4];
         tsafp_pkg::PH_OPCR:     return field_acc.flags[3];
         tsafp_pkg::PH_SPLICE:   return field_acc.flags[2];
         tsafp_pkg::PH_PRIVLEN:  return field_acc.flags[1];
         tsafp_pkg::PH_PRIVSKIP: return field_acc.flags[1] && skip_to_go != 0;
         tsafp_pkg::PH_EXTLEN,
         tsafp_pkg::PH_EXTFLAGS: return field_acc.flags[0];
         tsafp_pkg::PH_LTW:      return field_acc.ext_flags[3];
         tsafp_pkg::PH_PIECE:    return field_acc.ext_flags[2];
         tsafp_pkg::PH_SEAM:     return field_acc.ext_flags[1];
         default:                return 1'b1;
      endcase
   endfunction

   task automatic advance_phase(input tsafp_pkg::phase_type from);
      tsafp_pkg::phase_type p;
      p = tsafp_pkg::phase_type'(from + 1);
      while (p < tsafp_pkg::PH_STUFF && !phase_wanted(p))
         p = tsafp_pkg::phase_type'(p + 1);
      phase       = p;
      group_count = '0;
      group_bytes = '0;
   endtask

   task automatic shift_in(input logic [7:0] b, input int n, output logic full);
      group_bytes = {group_bytes[39:0], b};
      group_count = group_count + 3'd1;
      full        = (group_count >= n);
   endtask

   // 33-bit base in the top bits, 9-bit extension in the bottom bits.
   function automatic logic [41:0] clock_ref_value(input logic [47:0] g);
      logic [63:0] total;
      total = {31'd0, g[47:15]} * tsafp_pkg::CLOCK_REF_SCALE + {55'd0, g[8:0]};
      return total[41:0];
   endfunction

   task automatic predict_byte(input logic first, input logic [7:0] b);
      logic full;
      if (first) begin
         clear_field();
         if (b == 0)
            expected_fields.push_back(field_acc);
         else begin
            bytes_to_go            = b;
            field_acc.field_length = b;
            phase                  = tsafp_pkg::PH_FLAGS;
         end
      end else if (phase != tsafp_pkg::PH_IDLE) begin
         bytes_to_go = bytes_to_go - 8'd1;
         case (phase)
            tsafp_pkg::PH_FLAGS: begin
               field_acc.flags = b;
               advance_phase(tsafp_pkg::PH_FLAGS);
            end
            tsafp_pkg::PH_PCR, tsafp_pkg::PH_OPCR: begin
               shift_in(b, tsafp_pkg::PCR_BYTES, full);
               if (full) begin
                  if (phase == tsafp_pkg::PH_PCR)
                     field_acc.pcr = clock_ref_value(group_bytes);
                  else
                     field_acc.opcr = clock_ref_value(group_bytes);
                  advance_phase(phase);
               end
            end
            tsafp_pkg::PH_SPLICE: begin
               field_acc.countdown_byte = b;
               advance_phase(tsafp_pkg::PH_SPLICE);
            end
            tsafp_pkg::PH_PRIVLEN: begin
               field_acc.private_length = b;
               skip_to_go               = b;
               advance_phase(tsafp_pkg::PH_PRIVLEN);
            end
            tsafp_pkg::PH_PRIVSKIP: begin
               skip_to_go = skip_to_go - 8'd1;
               if (skip_to_go == 0)
                  advance_phase(tsafp_pkg::PH_PRIVSKIP);
            end
            tsafp_pkg::PH_EXTLEN: advance_phase(tsafp_pkg::PH_EXTLEN);
            tsafp_pkg::PH_EXTFLAGS: begin
               field_acc.ext_flags[3:1] = b[7:5];
               advance_phase(tsafp_pkg::PH_EXTFLAGS);
            end
            tsafp_pkg::PH_LTW: begin
               shift_in(b, tsafp_pkg::LTW_BYTES, full);
               if (full) begin
                  field_acc.ext_flags[0]  = group_bytes[15];
                  field_acc.window_offset = group_bytes[14:0];
                  advance_phase(tsafp_pkg::PH_LTW);
               end
            end
            tsafp_pkg::PH_PIECE: begin
               shift_in(b, tsafp_pkg::PIECE_BYTES, full);
               if (full) begin
                  field_acc.piece_rate = group_bytes[21:0];
                  advance_phase(tsafp_pkg::PH_PIECE);
               end
            end
            tsafp_pkg::PH_SEAM: begin
               shift_in(b, tsafp_pkg::SEAM_BYTES, full);
               if (full) begin
                  // Marker bits at 32, 16 and 0 are dropped.
                  field_acc.splice_code = group_bytes[39:36];
                  field_acc.next_dts    = {group_bytes[35:33], group_bytes[31:17],
                                           group_bytes[15:1]};
                  advance_phase(tsafp_pkg::PH_SEAM);
               end
            end
            default: ;
         endcase
         if (bytes_to_go == 0) begin
            field_acc.truncated = (phase != tsafp_pkg::PH_STUFF);
            expected_fields.push_back(field_acc);
            clear_field();
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endtask

   task automatic compare_result();
      tsafp_pkg::result_type want;
      if (expected_fields.size() == 0) begin
         $error("result with no field pending: tdata 0x%0h tuser %0b", rsp_tdata, rsp_tuser);
         failures++;
      end else begin
         want = expected_fields.pop_front();
         check_field("flags",          want.flags,          rsp_tdata[7:0]);
         check_field("pcr",            want.pcr,            rsp_tdata[49:8]);
         check_field("opcr",           want.opcr,           rsp_tdata[91:50]);
         check_field("countdown_byte", $unsigned(want.countdown_byte),
                     rsp_tdata[99:92]);
         check_field("private_length", want.private_length, rsp_tdata[107:100]);
         check_field("ext_flags",      want.ext_flags,      rsp_tdata[111:108]);
         check_field("window_offset",  want.window_offset,  rsp_tdata[126:112]);
         check_field("piece_rate",     want.piece_rate,     rsp_tdata[148:127]);
         check_field("splice_code",    want.splice_code,    rsp_tdata[152:149]);
         check_field("next_dts",       want.next_dts,       rsp_tdata[185:153]);
         check_field("field_length",   want.field_length,   rsp_tdata[193:186]);
         check_field("truncated",      want.truncated,      rsp_tuser);
         results_checked++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_field();
         expected_fields.delete();
         failures        = 0;
         results_checked = 0;
      end else begin
         if (req_tvalid && req_tready)
            predict_byte(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready)
            compare_result();
      end
      outstanding = expected_fields.size();
   end

endmodule

>>> tb/ts_adaptation_field_parser_core_tb.sv
// Stimulus and verdict for the transport-stream adaptation field parser.
`timescale 1ns / 1ps

module ts_adaptation_field_parser_core_tb;

   // Adaptation field flag masks used to lay out well-formed fields.
   localparam logic [7:0] AF_PCR       = 8'h10;
   localparam logic [7:0] AF_OPCR      = 8'h08;
   localparam logic [7:0] AF_SPLICE    = 8'h04;
   localparam logic [7:0] AF_PRIVATE   = 8'h02;
   localparam logic [7:0] AF_EXTENSION = 8'h01;
   localparam logic [7:0] EXT_LTW      = 8'h80;
   localparam logic [7:0] EXT_PIECE    = 8'h40;
   localparam logic [7:0] EXT_SEAM     = 8'h20;

   // Content fill styles for the value bytes of a field.
   localparam int FILL_RANDOM = 0;
   localparam int FILL_ONES   = 1;
   localparam int FILL_ZEROS  = 2;

   // Number of input items the whole run aims for.
   localparam int TARGET_ITEMS = 1050;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [7:0]                        req_tdata  = 8'h00;
   logic                              req_tuser  = 1'b0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [tsafp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                              rsp_tuser;

   int failures;
   int outstanding;
   int results_checked;

   // Idle rates in percent for the two sides; the stimulus process moves
   // them through the three pacing regimes.
   int send_idle_pct = 24;
   int recv_idle_pct = 69;

   // Bookkeeping for the closing summary.
   int field_bytes   = 0;
   int idle_bytes    = 0;
   int fields_sent   = 0;
   int zero_fields   = 0;
   int short_fields  = 0;
   int dropped       = 0;

   // Bytes after the length byte of the field being built.
   logic [7:0] body[$];

   always #4 clock = ~clock;

   ts_adaptation_field_parser_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ts_adaptation_field_parser_checker field_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .failures        (failures),
      .outstanding     (outstanding),
      .results_checked (results_checked)
   );

   // The receiver stalls at random each cycle according to the current rate.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Offers one item and returns at the edge where it is accepted. Before
   // the item goes out, the sender idles each cycle at the current rate, so
   // gaps land on every phase of the parse, including the middle of
   // multi-byte groups.
   task automatic send_byte(input logic first, input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= first;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [7:0] fill_byte(input int fill);
      case (fill)
         FILL_ONES:  return 8'hFF;
         FILL_ZEROS: return 8'h00;
         default:    return 8'($urandom_range(255));
      endcase
   endfunction

   // Lays out a well-formed field body: flags byte, then each flagged group
   // in stream order, then stuffing. The extension length byte carries a
   // throwaway value since the parser never uses it.
   task automatic build_field(input logic [7:0] flags, input logic [7:0] ext,
                              input int priv_len, input int stuff, input int fill);
      body.delete();
      body.push_back(flags);
      if ((flags & AF_PCR) != 0)
         repeat (tsafp_pkg::PCR_BYTES) body.push_back(fill_byte(fill));
      if ((flags & AF_OPCR) != 0)
         repeat (tsafp_pkg::PCR_BYTES) body.push_back(fill_byte(fill));
      if ((flags & AF_SPLICE) != 0) body.push_back(fill_byte(fill));
      if ((flags & AF_PRIVATE) != 0) begin
         body.push_back(8'(priv_len));
         repeat (priv_len) body.push_back(fill_byte(fill));
      end
      if ((flags & AF_EXTENSION) != 0) begin
         body.push_back(fill_byte(fill));
         body.push_back(ext);
         if ((ext & EXT_LTW) != 0)
            repeat (tsafp_pkg::LTW_BYTES) body.push_back(fill_byte(fill));
         if ((ext & EXT_PIECE) != 0)
            repeat (tsafp_pkg::PIECE_BYTES) body.push_back(fill_byte(fill));
         if ((ext & EXT_SEAM) != 0)
            repeat (tsafp_pkg::SEAM_BYTES) body.push_back(fill_byte(fill));
      end
      repeat (stuff) body.push_back(fill_byte(fill));
   endtask

   // Sends the length byte with the declared length, then the first
   // sent_count bytes of the body. Sending fewer than declared leaves the
   // field open, to be dropped by the next length byte.
   task automatic send_field(input int declared, input int sent_count);
      send_byte(1'b1, 8'(declared));
      for (int i = 0; i < sent_count; i++)
         send_byte(1'b0, body[i]);
      field_bytes += 1 + sent_count;
      fields_sent++;
      if (declared == 0)
         zero_fields++;
      else if (sent_count < declared)
         dropped++;
      else if (declared < body.size())
         short_fields++;
   endtask

   // Sends the whole body, clipped to the largest length a byte can declare.
   task automatic send_whole_field();
      int declared;
      declared = (body.size() > 255) ? 255 : body.size();
      send_field(declared, declared);
   endtask

   // One random field. Most are well formed with random content; some are
   // cut short by their length byte, some are abandoned mid-way, some have
   // zero length, and stray bytes sometimes arrive between fields.
   task automatic random_field(inout logic open);
      int pick;
      int priv_len;
      int declared;
      int sent_count;
      int fill;
      pick = $urandom_range(99);
      if (pick < 10) begin
         send_field(0, 0);
         open = 1'b0;
      end else begin
         if (pick < 16 && !open) begin
            repeat ($urandom_range(3, 1)) begin
               send_byte(1'b0, 8'($urandom_range(255)));
               idle_bytes++;
            end
         end
         // Long private data makes a field slow, so it stays rare.
         priv_len = ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(6);
         fill = ($urandom_range(9) == 0) ? $urandom_range(FILL_ZEROS, FILL_ONES)
                                         : FILL_RANDOM;
         build_field(8'($urandom_range(255)), 8'($urandom_range(255)), priv_len,
                     $urandom_range(3), fill);
         declared = (body.size() > 255) ? 255 : body.size();
         pick = $urandom_range(99);
         if (pick < 15 && declared > 1)
            declared = $urandom_range(declared - 1, 1);
         sent_count = declared;
         if (pick >= 15 && pick < 23)
            sent_count = $urandom_range(declared - 1, 0);
         send_field(declared, sent_count);
         open = (sent_count < declared);
      end
   endtask

   initial begin
      logic open;
      int   drain_wait;
      int   random_start;
      int   span;
      int   progress;
      open = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A stray byte with no field open must be ignored.
      send_byte(1'b0, 8'hA5);
      idle_bytes++;
      // Zero length gives an all-zero result at once.
      send_field(0, 0);
      // Flags only, nothing flagged.
      build_field(8'h00, 8'h00, 0, 0, FILL_RANDOM);
      send_whole_field();
      // Every flag and extension flag set, every value byte at its maximum.
      build_field(8'hFF, 8'hFF, 3, 2, FILL_ONES);
      send_whole_field();
      // Every group present with all-zero content and an empty private area.
      build_field(8'h1F, EXT_LTW | EXT_PIECE | EXT_SEAM, 0, 0, FILL_ZEROS);
      send_whole_field();
      // Length ends in the middle of the OPCR: later values read as zero.
      build_field(8'hFF, 8'hFF, 2, 0, FILL_RANDOM);
      send_field(10, 10);
      // Private data longer than the field can hold: skip still pending.
      build_field(AF_PRIVATE, 8'h00, 255, 0, FILL_RANDOM);
      send_whole_field();
      // A PCR field abandoned after four bytes, dropped by the next field.
      build_field(AF_PCR, 8'h00, 0, 0, FILL_RANDOM);
      send_field(body.size(), 4);
      // Largest declared length, almost all stuffing.
      build_field(8'h00, 8'h00, 0, 254, FILL_ONES);
      send_whole_field();
      // Length ends one byte short of the splice type and DTS group.
      build_field(AF_EXTENSION, EXT_SEAM, 0, 0, FILL_RANDOM);
      send_field(body.size() - 1, body.size() - 1);

      // Hold the sender off until every pending result is back.
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
      @(posedge clock);

      // Random part in three pacing regimes, each about a third of the
      // remaining items: sender light and receiver heavy idling, the
      // reverse, then full rate on both sides.
      random_start = field_bytes + idle_bytes;
      span         = TARGET_ITEMS - random_start;
      while (field_bytes + idle_bytes < TARGET_ITEMS) begin
         progress = field_bytes + idle_bytes - random_start;
         if (progress < span / 3) begin
            send_idle_pct = 24;
            recv_idle_pct = 69;
         end else if (progress < (2 * span) / 3) begin
            send_idle_pct = 69;
            recv_idle_pct = 24;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         random_field(open);
      end
      // A field left open gets closed by a zero-length field.
      if (open)
         send_field(0, 0);
      req_tvalid <= 1'b0;

      // Drain, then keep watching for any stray result to show up.
      drain_wait = 0;
      @(negedge clock);
      while (outstanding != 0 && drain_wait < 10000) begin
         @(negedge clock);
         drain_wait++;
      end
      repeat (10) @(negedge clock);
      if (outstanding != 0)
         $error("%0d expected results never arrived", outstanding);

      $display("Sent %0d fields in %0d bytes plus %0d stray bytes: %0d zero length,",
               fields_sent, field_bytes, idle_bytes, zero_fields);
      $display("%0d cut short by their length, %0d abandoned; %0d results compared.",
               short_fields, dropped, results_checked);
      if (failures == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
